[sv/srbcf_pkg.sv]
// Package for the sprite RLE blitter: screen size, register and opcode codes,
// FSM states, controller/datapath command and status structs, cursor saturation.
// No dependencies.
`default_nettype none

package srbcf_pkg;

  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 192;

  localparam logic [5:0] CNT_MASK = 6'h3F;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_FLIP_MODE,
    REG_SPRITE_WIDTH,
    REG_SPRITE_HEIGHT
  } srbcf_reg_e;

  typedef enum logic [1:0] {
    OP_LITERAL,
    OP_FILL,
    OP_SKIP,
    OP_JUMP
  } srbcf_op_e;

  typedef enum logic [2:0] {
    ST_START,
    ST_OPCODE,
    ST_LIT,
    ST_FILL,
    ST_SKIPEXT,
    ST_JUMPEXT,
    ST_JUMPCOL,
    ST_DRAIN
  } srbcf_state_e;

  typedef struct packed {
    logic start;
    logic ld_run;
    logic lit;
    logic fill_ld;
    logic fill_step;
    logic mv_x_cnt;
    logic mv_x_byte;
    logic mv_y_cnt;
    logic mv_y_byte;
    logic set_col;
    logic end_mark;
  } srbcf_cmd_t;

  typedef struct packed {
    srbcf_op_e op;
    logic      cnt_zero;
    logic      byte_zero;
    logic      run_zero;
    logic      run_one;
    logic      out_free;
  } srbcf_sts_t;

  function automatic logic signed [12:0] sat13(input logic signed [14:0] v);
    logic signed [12:0] r;
    if (v > 15'sd4095) begin
      r = 13'sd4095;
    end else if (v < -15'sd4096) begin
      r = -13'sd4096;
    end else begin
      r = 13'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/srbcf_in_if.sv]
// Input byte channel of the sprite RLE blitter.
// Depends on nothing.
`default_nettype none

interface srbcf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

`default_nettype wire

[sv/srbcf_out_if.sv]
// Pixel write channel of the sprite RLE blitter.
// Depends on nothing.
`default_nettype none

interface srbcf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_address;
  logic [7:0]  pixel_colour;
  logic        is_write;
  logic        last_of_run;

  modport source (output valid, output pixel_address, output pixel_colour,
                  output is_write, output last_of_run, input ready);
  modport sink   (input valid, input pixel_address, input pixel_colour,
                  input is_write, input last_of_run, output ready);
endinterface

`default_nettype wire

[sv/srbcf_ctrl.sv]
// Parser state machine of the sprite RLE blitter: steps through opcode and
// operand bytes, drains fill runs, issues datapath commands. Uses srbcf_pkg.
`default_nettype none

module srbcf_ctrl
  import srbcf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire srbcf_sts_t sts_i,
  output      srbcf_cmd_t cmd_o
);

  srbcf_state_e state_q, state_d;
  logic         fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q != ST_DRAIN) && sts_i.out_free;
    fire       = in_valid_i && in_ready_o;
    case (state_q)
      ST_START, ST_OPCODE: begin
        if (fire) begin
          cmd_o.start = (state_q == ST_START);
          case (sts_i.op)
            OP_LITERAL: begin
              cmd_o.ld_run = 1'b1;
              state_d      = sts_i.cnt_zero ? ST_OPCODE : ST_LIT;
            end
            OP_FILL: begin
              cmd_o.ld_run = 1'b1;
              state_d      = ST_FILL;
            end
            OP_SKIP: begin
              if (sts_i.cnt_zero) begin
                state_d = ST_SKIPEXT;
              end else begin
                cmd_o.mv_x_cnt = 1'b1;
                state_d        = ST_OPCODE;
              end
            end
            OP_JUMP: begin
              if (sts_i.cnt_zero) begin
                state_d = ST_JUMPEXT;
              end else begin
                cmd_o.mv_y_cnt = 1'b1;
                state_d        = ST_JUMPCOL;
              end
            end
            default: state_d = ST_OPCODE;
          endcase
        end
      end
      ST_LIT: begin
        if (fire) begin
          cmd_o.lit = 1'b1;
          state_d   = sts_i.run_one ? ST_OPCODE : ST_LIT;
        end
      end
      ST_FILL: begin
        if (fire) begin
          cmd_o.fill_ld = 1'b1;
          state_d       = sts_i.run_zero ? ST_OPCODE : ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts_i.out_free) begin
          cmd_o.fill_step = 1'b1;
          if (sts_i.run_one) begin
            state_d = ST_OPCODE;
          end
        end
      end
      ST_SKIPEXT: begin
        if (fire) begin
          cmd_o.mv_x_byte = 1'b1;
          state_d         = ST_OPCODE;
        end
      end
      ST_JUMPEXT: begin
        if (fire) begin
          if (sts_i.byte_zero) begin
            cmd_o.end_mark = 1'b1;
            state_d        = ST_START;
          end else begin
            cmd_o.mv_y_byte = 1'b1;
            state_d         = ST_JUMPCOL;
          end
        end
      end
      ST_JUMPCOL: begin
        if (fire) begin
          cmd_o.set_col = 1'b1;
          state_d       = ST_OPCODE;
        end
      end
      default: state_d = ST_START;
    endcase
  end

endmodule

`default_nettype wire

[sv/srbcf_dp.sv]
// Datapath of the sprite RLE blitter: config registers, cursors with flip and
// saturation, clip test, run counter and the output register. Uses srbcf_pkg.
`default_nettype none

module srbcf_dp
  import srbcf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic [7:0]            in_byte_i,
  input  wire srbcf_cmd_t            cmd_i,
  output      srbcf_sts_t            sts_o,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [15:0]           out_addr_o,
  output      logic [7:0]            out_colour_o,
  output      logic                  out_write_o,
  output      logic                  out_last_o
);

  localparam logic signed [13:0] SW_S = 14'(SCREEN_WIDTH);
  localparam logic signed [13:0] SH_S = 14'(SCREEN_HEIGHT);

  function automatic logic in_range(input logic signed [12:0] v, input int lim);
    return !v[12] && (v[11:0] < 12'(lim));
  endfunction

  logic signed [11:0] origin_x_q, origin_y_q;
  logic [1:0]         flip_mode_q;
  logic [9:0]         width_q, height_q;

  logic               hflip_q, hflip_d, vflip_q, vflip_d;
  logic signed [12:0] cx_q, cx_d, cy_q, cy_d, ls_q, ls_d;
  logic [5:0]         run_q, run_d;
  logic [7:0]         fill_col_q, fill_col_d;
  logic               suppress_q, suppress_d;

  logic               out_valid_q, out_valid_d;
  logic [15:0]        addr_q, addr_d;
  logic [7:0]         col_q, col_d;
  logic               wr_q, wr_d, last_q, last_d;

  logic signed [12:0] sx, sy, start_cx, start_cy, base_x, base_y, step_x, step_y;
  logic signed [12:0] col_x;
  logic signed [13:0] x2, y2;
  logic signed [14:0] sum_x, sum_y, sum_c;
  logic               hf, vf, start_sup, vis, out_free;
  logic [5:0]         cnt;
  logic [7:0]         dx, dy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      flip_mode_q <= '0;
      width_q     <= 10'd1;
      height_q    <= 10'd1;
    end else if (cfg_we_i) begin
      case (srbcf_reg_e'(cfg_idx_i))
        REG_ORIGIN_X:      origin_x_q  <= cfg_wdata_i;
        REG_ORIGIN_Y:      origin_y_q  <= cfg_wdata_i;
        REG_FLIP_MODE:     flip_mode_q <= cfg_wdata_i[1:0];
        REG_SPRITE_WIDTH:  width_q     <= cfg_wdata_i[9:0];
        REG_SPRITE_HEIGHT: height_q    <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt = in_byte_i[5:0] & CNT_MASK;

    sx       = 13'(origin_x_q);
    sy       = 13'(origin_y_q);
    x2       = 14'(sx) + 14'({4'b0, width_q}) - 14'sd1;
    y2       = 14'(sy) + 14'({4'b0, height_q}) - 14'sd1;
    start_cx = flip_mode_q[0] ? 13'(x2) : sx;
    start_cy = flip_mode_q[1] ? 13'(y2) : sy;
    start_sup = (14'(sy) >= SH_S) || (y2 < 14'sd0) ||
                (14'(sx) >= SW_S) || (x2 < 14'sd0);

    hf     = cmd_i.start ? flip_mode_q[0] : hflip_q;
    vf     = cmd_i.start ? flip_mode_q[1] : vflip_q;
    base_x = cmd_i.start ? start_cx : cx_q;
    base_y = cmd_i.start ? start_cy : cy_q;

    if (cmd_i.mv_x_cnt) begin
      dx = {2'b0, cnt};
    end else if (cmd_i.mv_x_byte) begin
      dx = in_byte_i;
    end else begin
      dx = 8'd1;
    end
    dy = cmd_i.mv_y_cnt ? {2'b0, cnt} : in_byte_i;

    sum_x  = hf ? (15'(base_x) - 15'({7'b0, dx})) : (15'(base_x) + 15'({7'b0, dx}));
    sum_y  = vf ? (15'(base_y) - 15'({7'b0, dy})) : (15'(base_y) + 15'({7'b0, dy}));
    sum_c  = hflip_q ? (15'(ls_q) - 15'({7'b0, in_byte_i}))
                     : (15'(ls_q) + 15'({7'b0, in_byte_i}));
    step_x = sat13(sum_x);
    step_y = sat13(sum_y);
    col_x  = sat13(sum_c);

    vis      = !suppress_q && in_range(cx_q, SCREEN_WIDTH) && in_range(cy_q, SCREEN_HEIGHT);
    out_free = !out_valid_q || out_ready_i;

    hflip_d    = hflip_q;
    vflip_d    = vflip_q;
    suppress_d = suppress_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    ls_d       = ls_q;
    run_d      = run_q;
    fill_col_d = fill_col_q;

    if (cmd_i.start) begin
      hflip_d    = flip_mode_q[0];
      vflip_d    = flip_mode_q[1];
      suppress_d = start_sup;
      cx_d       = start_cx;
      cy_d       = start_cy;
      ls_d       = start_cx;
      run_d      = '0;
    end
    if (cmd_i.mv_x_cnt || cmd_i.mv_x_byte || cmd_i.lit || cmd_i.fill_step) begin
      cx_d = step_x;
    end else if (cmd_i.set_col) begin
      cx_d = col_x;
    end
    if (cmd_i.mv_y_cnt || cmd_i.mv_y_byte) begin
      cy_d = step_y;
    end
    if (cmd_i.ld_run) begin
      run_d = cnt;
    end else if (cmd_i.lit || cmd_i.fill_step) begin
      run_d = run_q - 6'd1;
    end
    if (cmd_i.fill_ld) begin
      fill_col_d = in_byte_i;
    end

    out_valid_d = out_valid_q && !out_ready_i;
    addr_d      = addr_q;
    col_d       = col_q;
    wr_d        = wr_q;
    last_d      = last_q;
    if ((cmd_i.lit || cmd_i.fill_step) && vis) begin
      out_valid_d = 1'b1;
      addr_d      = 16'(16'(cy_q) * 16'(SCREEN_WIDTH)) + 16'(cx_q);
      col_d       = cmd_i.lit ? in_byte_i : fill_col_q;
      wr_d        = 1'b1;
      last_d      = cmd_i.lit || (run_q == 6'd1) || !in_range(step_x, SCREEN_WIDTH);
    end else if (cmd_i.end_mark) begin
      out_valid_d = 1'b1;
      addr_d      = '0;
      col_d       = '0;
      wr_d        = 1'b0;
      last_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hflip_q     <= 1'b0;
      vflip_q     <= 1'b0;
      suppress_q  <= 1'b0;
      cx_q        <= '0;
      cy_q        <= '0;
      ls_q        <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hflip_q     <= hflip_d;
      vflip_q     <= vflip_d;
      suppress_q  <= suppress_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      ls_q        <= ls_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_col_q <= fill_col_d;
    addr_q     <= addr_d;
    col_q      <= col_d;
    wr_q       <= wr_d;
    last_q     <= last_d;
  end

  always_comb begin
    sts_o.op        = srbcf_op_e'(in_byte_i[7:6]);
    sts_o.cnt_zero  = (cnt == 6'd0);
    sts_o.byte_zero = (in_byte_i == 8'd0);
    sts_o.run_zero  = (run_q == 6'd0);
    sts_o.run_one   = (run_q == 6'd1);
    sts_o.out_free  = out_free;
  end

  assign out_valid_o  = out_valid_q;
  assign out_addr_o   = addr_q;
  assign out_colour_o = col_q;
  assign out_write_o  = wr_q;
  assign out_last_o   = last_q;

endmodule

`default_nettype wire

[sv/sprite_rle_blitter_clip_flip_unit.sv]
// Top level of the sprite RLE blitter: parser FSM plus cursor/clip datapath.
// Uses srbcf_pkg, srbcf_in_if, srbcf_out_if, srbcf_ctrl, srbcf_dp.
//
//   channel | direction | payload
//   in_i    | sink      | stream_byte
//   out_o   | source    | pixel_address, pixel_colour, is_write, last_of_run
//   cfg     | write     | cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// A fill colour byte with count N starts a drain of N pixel steps, one pixel per
// cycle while the output register is free; input waits until the drain ends.
// One output register holds each result; a stall there holds input.
// Reset clears parser, cursors and registers; no clearing pass.
`default_nettype none

module sprite_rle_blitter_clip_flip_unit
  import srbcf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  srbcf_in_if.sink                   in_i,
  srbcf_out_if.source                out_o
);

  srbcf_cmd_t cmd;
  srbcf_sts_t sts;

  srbcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srbcf_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_byte_i    (in_i.stream_byte),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_addr_o   (out_o.pixel_address),
    .out_colour_o (out_o.pixel_colour),
    .out_write_o  (out_o.is_write),
    .out_last_o   (out_o.last_of_run)
  );

endmodule

`default_nettype wire

[sv/srbcf_checker.sv]
// Port-level checks for the sprite RLE blitter, bound to the top level.
// Depends on sprite_rle_blitter_clip_flip_unit.
`default_nettype none

module srbcf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] out_addr_i,
  input wire logic [7:0]  out_colour_i,
  input wire logic        out_write_i,
  input wire logic        out_last_i
);

  a_end_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_write_i |-> out_addr_i == 16'd0 && out_colour_i == 8'd0 && out_last_i)
    else $error("end marker payload wrong");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_addr_i) && $stable(out_colour_i))
    else $error("stalled item changed");

  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i || out_ready_i)
    else $error("item taken while result stalled");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_write_i && !out_last_i |=> out_valid_i && out_write_i)
    else $error("run ended without last flag");

endmodule

bind sprite_rle_blitter_clip_flip_unit srbcf_checker u_srbcf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_addr_i   (out_o.pixel_address),
  .out_colour_i (out_o.pixel_colour),
  .out_write_i  (out_o.is_write),
  .out_last_i   (out_o.last_of_run)
);

`default_nettype wire

[sim/tb_sprite_rle_blitter_clip_flip_unit.sv]
// Testbench for sprite_rle_blitter_clip_flip_unit: feeds encoded sprite bytes, predicts
// every pixel write and end marker, and compares them in order. Needs srbcf_pkg and the
// srbcf_in_if / srbcf_out_if interfaces.
`timescale 1ns / 100ps

module tb_sprite_rle_blitter_clip_flip_unit
  import srbcf_pkg::*;
();

  localparam int DIRECTED_LEN = 22;
  localparam int RANDOM_ITEMS = 460;
  localparam int SETTLE       = 80;
  localparam int LONG_HOLD    = 300;

  typedef struct {
    logic [15:0] pixel_address;
    logic [7:0]  pixel_colour;
    logic        is_write;
    logic        last_of_run;
  } pixel_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  srbcf_in_if  in_if ();
  srbcf_out_if out_if ();

  sprite_rle_blitter_clip_flip_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [7:0] sprite_bytes[$];
  pixel_t     pending_pixels[$];
  int         sent_cnt  = 0;
  int         fail_cnt  = 0;
  int         hold_req  = 0;
  int         hold_seen = 0;
  int         tx_gap    = 0;
  int         rx_wait   = 0;
  bit         tx_calm   = 1'b0;
  bit         rx_calm   = 1'b0;

  // register copies, reset values
  logic [11:0] org_x  = '0;
  logic [11:0] org_y  = '0;
  logic [1:0]  flip   = '0;
  logic [9:0]  spr_w  = 10'd1;
  logic [9:0]  spr_h  = 10'd1;

  // decoder state
  srbcf_state_e parse_st = ST_START;
  int cur_x   = 0;
  int cur_y   = 0;
  int line_x  = 0;
  int run_left = 0;
  bit hide_all = 1'b0;
  bit hflip   = 1'b0;
  bit vflip   = 1'b0;

  function automatic int clamp13(input int v);
    if (v < -4096) return -4096;
    if (v > 4095) return 4095;
    return v;
  endfunction

  task automatic move_x(input int d);
    cur_x = clamp13(hflip ? cur_x - d : cur_x + d);
  endtask

  task automatic move_y(input int d);
    cur_y = clamp13(vflip ? cur_y - d : cur_y + d);
  endtask

  task automatic put_pixel(input logic [7:0] col);
    pixel_t px;
    if (!hide_all && cur_x >= 0 && cur_x < SCREEN_WIDTH &&
        cur_y >= 0 && cur_y < SCREEN_HEIGHT) begin
      px = '{16'(cur_y * SCREEN_WIDTH + cur_x), col, 1'b1, 1'b0};
      pending_pixels.push_back(px);
    end
  endtask

  // registers are sampled when a sprite's first opcode arrives
  task automatic begin_sprite();
    int x, y, x2, y2;
    x  = $signed(org_x);
    y  = $signed(org_y);
    x2 = x + int'(spr_w) - 1;
    y2 = y + int'(spr_h) - 1;
    hflip    = flip[0];
    vflip    = flip[1];
    hide_all = (y >= SCREEN_HEIGHT) || (y2 < 0) || (x >= SCREEN_WIDTH) || (x2 < 0);
    cur_x    = hflip ? x2 : x;
    cur_y    = vflip ? y2 : y;
    line_x   = cur_x;
    run_left = 0;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    int     n0;
    int     cnt;
    pixel_t px;
    n0  = pending_pixels.size();
    cnt = int'(b[5:0]);
    case (parse_st)
      ST_LIT: begin
        put_pixel(b);
        move_x(1);
        run_left--;
        parse_st = (run_left == 0) ? ST_OPCODE : ST_LIT;
      end
      ST_FILL: begin
        for (int i = 0; i < run_left; i++) begin
          put_pixel(b);
          move_x(1);
        end
        run_left = 0;
        parse_st = ST_OPCODE;
      end
      ST_SKIPEXT: begin
        move_x(int'(b));
        parse_st = ST_OPCODE;
      end
      ST_JUMPEXT: begin
        if (b == 8'd0) begin
          px = '{16'd0, 8'd0, 1'b0, 1'b0};
          pending_pixels.push_back(px);
          parse_st = ST_START;
        end else begin
          move_y(int'(b));
          parse_st = ST_JUMPCOL;
        end
      end
      ST_JUMPCOL: begin
        cur_x = clamp13(hflip ? line_x - int'(b) : line_x + int'(b));
        parse_st = ST_OPCODE;
      end
      default: begin
        if (parse_st != ST_OPCODE) begin_sprite();
        case (srbcf_op_e'(b[7:6]))
          OP_LITERAL: begin
            run_left = cnt;
            parse_st = (cnt == 0) ? ST_OPCODE : ST_LIT;
          end
          OP_FILL: begin
            run_left = cnt;
            parse_st = ST_FILL;
          end
          OP_SKIP: begin
            if (cnt == 0) begin
              parse_st = ST_SKIPEXT;
            end else begin
              move_x(cnt);
              parse_st = ST_OPCODE;
            end
          end
          default: begin
            if (cnt == 0) begin
              parse_st = ST_JUMPEXT;
            end else begin
              move_y(cnt);
              parse_st = ST_JUMPCOL;
            end
          end
        endcase
      end
    endcase
    if (pending_pixels.size() > n0)
      pending_pixels[pending_pixels.size() - 1].last_of_run = 1'b1;
  endtask

  task automatic check_field(input string fld, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      fail_cnt++;
      $error("%s: expected 0x%0h, got 0x%0h", fld, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin : byte_driver
    logic       nxt_valid;
    logic [7:0] nxt_byte;
    nxt_valid = in_if.valid;
    nxt_byte  = in_if.stream_byte;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        decode_byte(in_if.stream_byte);
        nxt_valid = 1'b0;
        if ($urandom_range(0, 47) == 0) tx_calm = !tx_calm;
        tx_gap = tx_calm ? 0 : $urandom_range(0, 4);
      end
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (sprite_bytes.size() > 0) begin
          nxt_byte  = sprite_bytes.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_if.valid       <= nxt_valid;
      in_if.stream_byte <= nxt_byte;
    end
  end

  always @(posedge clk_i) begin : pixel_monitor
    pixel_t exp_px;
    if (rst_ni) begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        rx_wait   = LONG_HOLD;
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_pixels.size() == 0) begin
          fail_cnt++;
          $error("unexpected item: address 0x%0h colour 0x%0h is_write %0b",
                 out_if.pixel_address, out_if.pixel_colour, out_if.is_write);
        end else begin
          exp_px = pending_pixels.pop_front();
          check_field("pixel_address", exp_px.pixel_address, out_if.pixel_address);
          check_field("pixel_colour", 16'(exp_px.pixel_colour), 16'(out_if.pixel_colour));
          check_field("is_write", 16'(exp_px.is_write), 16'(out_if.is_write));
          check_field("last_of_run", 16'(exp_px.last_of_run), 16'(out_if.last_of_run));
        end
        if ($urandom_range(0, 47) == 0) rx_calm = !rx_calm;
        if (rx_wait == 0) rx_wait = rx_calm ? 0 : $urandom_range(0, 4);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send(input logic [7:0] b);
    sprite_bytes.push_back(b);
    sent_cnt++;
  endtask

  task automatic write_reg(input srbcf_reg_e idx, input logic [11:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_ORIGIN_X:      org_x = val;
      REG_ORIGIN_Y:      org_y = val;
      REG_FLIP_MODE:     flip  = val[1:0];
      REG_SPRITE_WIDTH:  spr_w = val[9:0];
      REG_SPRITE_HEIGHT: spr_h = val[9:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [11:0] ox, input logic [11:0] oy,
                             input logic [1:0] fm, input logic [9:0] w,
                             input logic [9:0] h);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_FLIP_MODE, 12'(fm));
    write_reg(REG_SPRITE_WIDTH, 12'(w));
    write_reg(REG_SPRITE_HEIGHT, 12'(h));
  endtask

  // all bytes taken, all results back, then let a silent fill drain
  task automatic wait_idle();
    do @(negedge clk_i);
    while (sprite_bytes.size() != 0 || in_if.valid || pending_pixels.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic add_sprite(input int ops);
    int k, n;
    repeat (ops) begin
      k = $urandom_range(0, 99);
      if (k < 35) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
        send({OP_LITERAL, 6'(n)});
        repeat (n) send(8'($urandom()));
      end else if (k < 58) begin
        n = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
        send({OP_FILL, 6'(n)});
        send(8'($urandom()));
      end else if (k < 72) begin
        if ($urandom_range(0, 19) == 0) begin
          // run x into saturation
          repeat (18) begin
            send({OP_SKIP, 6'd0});
            send(8'hFF);
          end
        end else if ($urandom_range(0, 2) == 0) begin
          send({OP_SKIP, 6'd0});
          send(8'($urandom()));
        end else begin
          send({OP_SKIP, 6'($urandom_range(1, 63))});
        end
      end else if (k < 94) begin
        if ($urandom_range(0, 24) == 0) begin
          repeat (18) begin
            send({OP_JUMP, 6'd0});
            send(8'hFF);
            send(8'($urandom_range(0, 40)));
          end
        end else begin
          if ($urandom_range(0, 3) == 0) begin
            send({OP_JUMP, 6'd0});
            send(8'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                 : $urandom_range(1, 3)));
          end else begin
            send({OP_JUMP, 6'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 63)
                                                          : $urandom_range(1, 2))});
          end
          send(8'(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 48)));
        end
      end else begin
        send(8'($urandom()));
      end
    end
    send({OP_JUMP, 6'd0});
    send(8'h00);
  endtask

  task automatic random_config();
    logic [11:0] ox, oy;
    logic [9:0]  w, h;
    ox = ($urandom_range(0, 3) == 0) ? 12'($urandom()) : 12'($urandom_range(0, 280)) - 12'd24;
    oy = ($urandom_range(0, 3) == 0) ? 12'($urandom()) : 12'($urandom_range(0, 210)) - 12'd16;
    w  = 10'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 1023) : $urandom_range(1, 80));
    h  = 10'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 1023) : $urandom_range(1, 80));
    load_config(ox, oy, 2'($urandom_range(0, 3)), w, h);
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = REG_ORIGIN_X;
    cfg_wdata_i       = '0;
    in_if.valid       = 1'b0;
    in_if.stream_byte = '0;
    out_if.ready      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed sprite on reset registers
    send(8'h7F); send(8'h3C);                 // fill 63
    send(8'h02); send(8'h00); send(8'hFF);    // literal 2, colour extremes
    send(8'h00);                              // empty literal
    send(8'h43); send(8'hA5);                 // fill 3
    send(8'h40); send(8'h5A);                 // empty fill still eats colour
    send(8'h85);                              // skip 5
    wait_idle();                              // sender pause mid-sprite
    send(8'h80); send(8'hFF);                 // skip by extension 255
    send(8'h01); send(8'h77);                 // off-screen pixel
    send(8'hC2); send(8'h03);                 // jump 2, column 3
    send(8'hC0); send(8'h05); send(8'h00);    // jump by extension 5, column 0
    send(8'hC0); send(8'h00);                 // end of sprite
    wait_idle();

    load_config(12'h800, 12'h800, 2'd3, 10'd1023, 10'd1023);
    add_sprite(6);
    wait_idle();
    load_config(12'h7FF, 12'h7FF, 2'd0, 10'd1, 10'd1);
    add_sprite(6);
    wait_idle();
    load_config(12'd250, 12'd185, 2'd1, 10'd8, 10'd8);
    add_sprite(8);
    wait_idle();
    load_config(-12'sd5, -12'sd3, 2'd2, 10'd40, 10'd12);
    add_sprite(8);
    wait_idle();

    // long receiver stall while the sender keeps going
    load_config(12'd20, 12'd20, 2'd0, 10'd64, 10'd64);
    hold_req++;
    add_sprite(10);
    wait_idle();

    while (sent_cnt < DIRECTED_LEN + RANDOM_ITEMS) begin
      random_config();
      repeat ($urandom_range(1, 3)) add_sprite($urandom_range(3, 10));
      wait_idle();
    end

    if (fail_cnt == 0) begin
      $display("[sprite_rle_blitter_clip_flip_unit] OK");
    end else begin
      $display("[sprite_rle_blitter_clip_flip_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #(64'd16_000_000);
    $display("[sprite_rle_blitter_clip_flip_unit] ERROR");
    $finish;
  end

endmodule
